FILE: rtl/lobm_pkg.sv
// ----------------------------------------------------------------------------
// Order book matcher package
// Shared sizes and the resting-order record.
// ----------------------------------------------------------------------------
package lobm_pkg;

    localparam int BOOK_DEPTH = 32;
    localparam int PRICE_BITS = 20;
    localparam int VOL_BITS   = 32;
    localparam int ID_BITS    = 32;
    localparam int CNT_BITS   = $clog2(BOOK_DEPTH + 1);

    typedef struct packed {
        logic [PRICE_BITS-1:0] price;
        logic [VOL_BITS-1:0]   vol;
        logic [ID_BITS-1:0]    id;
    } t_entry;

    typedef struct packed {
        logic   pop;
        logic   ins;
        logic   desc;
        t_entry item;
        logic   upd;
        logic [VOL_BITS-1:0] head_vol;
    } t_cell_ctl;

endpackage

FILE: rtl/lobm_cell.sv
// ----------------------------------------------------------------------------
// Book cell
// One slot of a sorted side; shifts toward the head on pop, away on insert.
// ----------------------------------------------------------------------------
module lobm_cell
    import lobm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_is_head,
    input  t_entry    i_prev,
    input  logic      i_prev_occ,
    input  logic      i_prev_after,
    input  t_entry    i_next,
    input  logic      i_next_occ,
    output t_entry    o_entry,
    output logic      o_occ,
    output logic      o_after
);

    t_entry r_entry;
    logic   r_occ;
    logic   w_after;

    // new item goes behind this cell (cell price equal or better)
    assign w_after = r_occ && (i_ctl.desc ? (r_entry.price >= i_ctl.item.price)
                                          : (r_entry.price <= i_ctl.item.price));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (i_ctl.pop) begin
            r_occ <= i_next_occ;
        end else if (i_ctl.ins) begin
            r_occ <= r_occ || (i_is_head ? 1'b1 : (i_prev_occ || i_prev_after));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            r_entry <= i_next;
        end else if (i_ctl.ins) begin
            if (!w_after) begin
                if (i_is_head || i_prev_after) begin
                    r_entry <= i_ctl.item;
                end else begin
                    r_entry <= i_prev;
                end
            end
        end else if (i_ctl.upd && i_is_head) begin
            r_entry.vol <= i_ctl.head_vol;
        end
    end

    assign o_entry = r_entry;
    assign o_occ   = r_occ;
    assign o_after = w_after;

endmodule

FILE: rtl/lobm_side.sv
// ----------------------------------------------------------------------------
// Book side
// Chain of cells holding one side, best price at the head.
// ----------------------------------------------------------------------------
module lobm_side
    import lobm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    output t_entry    o_head,
    output t_entry    o_next,
    output logic      o_next_occ,
    output logic      o_empty,
    output logic      o_full
);

    t_entry w_ent   [BOOK_DEPTH];
    logic   w_occ   [BOOK_DEPTH];
    logic   w_after [BOOK_DEPTH];

    genvar g;
    generate
        for (g = 0; g < BOOK_DEPTH; g++) begin : g_cell
            t_entry w_prev, w_next;
            logic   w_prev_occ, w_prev_after, w_next_occ;
            if (g == 0) begin : g_h
                assign w_prev       = '0;
                assign w_prev_occ   = 1'b0;
                assign w_prev_after = 1'b0;
            end else begin : g_m
                assign w_prev       = w_ent[g-1];
                assign w_prev_occ   = w_occ[g-1];
                assign w_prev_after = w_after[g-1];
            end
            if (g == BOOK_DEPTH - 1) begin : g_t
                assign w_next     = '0;
                assign w_next_occ = 1'b0;
            end else begin : g_n
                assign w_next     = w_ent[g+1];
                assign w_next_occ = w_occ[g+1];
            end
            lobm_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (i_ctl),
                .i_is_head    (g == 0),
                .i_prev       (w_prev),
                .i_prev_occ   (w_prev_occ),
                .i_prev_after (w_prev_after),
                .i_next       (w_next),
                .i_next_occ   (w_next_occ),
                .o_entry      (w_ent[g]),
                .o_occ        (w_occ[g]),
                .o_after      (w_after[g])
            );
        end
    endgenerate

    assign o_head     = w_ent[0];
    assign o_next     = w_ent[1];
    assign o_next_occ = w_occ[1];
    assign o_empty    = !w_occ[0];
    assign o_full     = w_occ[BOOK_DEPTH-1];

endmodule

FILE: rtl/limit_order_book_matcher.sv
// ----------------------------------------------------------------------------
// Limit order book matcher
// Price-time priority matching of limit orders against a two-sided book.
// ----------------------------------------------------------------------------
// An order is taken when start is high and busy is low. It then gives one
// result per cycle: one per trade against the head cell of the opposite side,
// or a single acknowledge when nothing crosses; the final one carries o_last.
// A remainder that is left over is rested or dropped in S_REST, which gives
// no result; busy is high throughout S_MATCH and S_REST. Each result is on
// the ports for one cycle under o_valid and cannot be held off.
module limit_order_book_matcher
    import lobm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  i_is_buy,
    input  logic [PRICE_BITS-1:0] i_price_ticks,
    input  logic [VOL_BITS-1:0]   i_order_volume,
    output logic                  busy,
    output logic                  o_valid,
    output logic [ID_BITS-1:0]    o_assigned_id,
    output logic                  o_trade_valid,
    output logic [VOL_BITS-1:0]   o_trade_volume,
    output logic [PRICE_BITS-1:0] o_trade_price,
    output logic [ID_BITS-1:0]    o_ask_order_id,
    output logic                  o_book_full,
    output logic                  o_last
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MATCH = 3'b010,
        S_REST  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic                  r_buy;
    logic [PRICE_BITS-1:0] r_price;
    logic [VOL_BITS-1:0]   r_vol;
    logic [ID_BITS-1:0]    r_oid, r_next_id;

    t_cell_ctl w_bid_ctl, w_ask_ctl;
    t_entry    w_bid_head, w_ask_head, w_opp;
    t_entry    w_bid_next, w_ask_next, w_opp_next;
    logic      w_bid_next_occ, w_ask_next_occ, w_opp_next_occ;
    logic      w_bid_empty, w_ask_empty, w_bid_full, w_ask_full;
    logic      w_opp_empty, w_cross, w_next_cross, w_own_full;
    logic [VOL_BITS-1:0] w_tv, w_rem, w_head_rem;

    lobm_side u_bid (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_bid_ctl),
        .o_head(w_bid_head), .o_next(w_bid_next), .o_next_occ(w_bid_next_occ),
        .o_empty(w_bid_empty), .o_full(w_bid_full));
    lobm_side u_ask (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ask_ctl),
        .o_head(w_ask_head), .o_next(w_ask_next), .o_next_occ(w_ask_next_occ),
        .o_empty(w_ask_empty), .o_full(w_ask_full));

    assign w_opp          = r_buy ? w_ask_head : w_bid_head;
    assign w_opp_next     = r_buy ? w_ask_next : w_bid_next;
    assign w_opp_next_occ = r_buy ? w_ask_next_occ : w_bid_next_occ;
    assign w_opp_empty    = r_buy ? w_ask_empty : w_bid_empty;
    assign w_own_full     = r_buy ? w_bid_full : w_ask_full;
    assign w_cross        = !w_opp_empty && (r_buy ? (r_price >= w_opp.price)
                                                   : (w_opp.price >= r_price));
    // cell behind the head crosses too (matters only when the head pops)
    assign w_next_cross   = w_opp_next_occ && (r_buy ? (r_price >= w_opp_next.price)
                                                     : (w_opp_next.price >= r_price));
    assign w_tv           = (r_vol < w_opp.vol) ? r_vol : w_opp.vol;
    assign w_rem          = r_vol - w_tv;
    assign w_head_rem     = w_opp.vol - w_tv;

    logic w_match, w_trade, w_more, w_rest;
    assign w_match = (r_state == S_MATCH);
    assign w_trade = w_match && w_cross;
    assign w_more  = w_trade && (w_rem != '0) && w_next_cross;
    assign w_rest  = (r_state == S_REST);

    always_comb begin
        t_cell_ctl c;
        c.pop       = w_trade && (w_head_rem == '0);
        c.upd       = w_trade;
        c.head_vol  = w_head_rem;
        c.ins       = 1'b0;
        c.desc      = 1'b0;
        c.item      = '0;
        w_bid_ctl   = '0;
        w_ask_ctl   = '0;
        w_bid_ctl.desc       = 1'b1;
        w_bid_ctl.item.price = r_price;
        w_bid_ctl.item.vol   = r_vol;
        w_bid_ctl.item.id    = r_oid;
        w_ask_ctl.item       = w_bid_ctl.item;
        if (r_buy) begin
            w_ask_ctl.pop      = c.pop;
            w_ask_ctl.upd      = c.upd;
            w_ask_ctl.head_vol = c.head_vol;
            w_bid_ctl.ins      = w_rest && !w_bid_full;
        end else begin
            w_bid_ctl.pop      = c.pop;
            w_bid_ctl.upd      = c.upd;
            w_bid_ctl.head_vol = c.head_vol;
            w_ask_ctl.ins      = w_rest && !w_ask_full;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (start) n_state = S_MATCH;
            S_MATCH: begin
                if (w_more) begin
                    n_state = S_MATCH;
                end else if (w_cross && w_rem == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_REST;
                end
            end
            S_REST:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_next_id <= ID_BITS'(1);
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && start) begin
                r_next_id <= r_next_id + ID_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_buy   <= i_is_buy;
            r_price <= i_price_ticks;
            r_vol   <= i_order_volume;
            r_oid   <= r_next_id;
        end else if (w_trade) begin
            r_vol <= w_rem;
        end
    end

    always_comb begin
        o_valid        = w_match;
        o_assigned_id  = r_oid;
        o_trade_valid  = w_trade;
        o_trade_volume = w_trade ? w_tv : '0;
        o_trade_price  = w_trade ? (r_buy ? w_opp.price : r_price) : '0;
        o_ask_order_id = w_trade ? (r_buy ? w_opp.id : r_oid) : '0;
        o_last         = w_match && !w_more;
        o_book_full    = w_match && !w_more && (!w_cross || w_rem != '0) && w_own_full;
    end

    assign busy = (r_state != S_IDLE);

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !busy)
            $error("result without order in flight");
    end

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result beat after the last one");
    a_full_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_book_full |-> o_last)
        else $error("book full flagged on non-final result");
    a_id_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_next_id == $past(r_next_id) + ID_BITS'(1)))
        else $error("order id did not advance");

endmodule

FILE: verif/lobm_fill_checker.sv
// ----------------------------------------------------------------------------
// Order book fill checker
// Watches the order and fill channels of the matcher. It keeps its own copy
// of both sides of the book, works out the fills that each accepted order
// must give, and compares every fill beat field by field.
// ----------------------------------------------------------------------------
module lobm_fill_checker
    import lobm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_is_buy,
    input  logic [PRICE_BITS-1:0] i_price_ticks,
    input  logic [VOL_BITS-1:0]   i_order_volume,
    input  logic                  i_busy,
    input  logic                  i_valid,
    input  logic [ID_BITS-1:0]    i_assigned_id,
    input  logic                  i_trade_valid,
    input  logic [VOL_BITS-1:0]   i_trade_volume,
    input  logic [PRICE_BITS-1:0] i_trade_price,
    input  logic [ID_BITS-1:0]    i_ask_order_id,
    input  logic                  i_book_full,
    input  logic                  i_last,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [ID_BITS-1:0]    oid;
        logic                  trade;
        logic [VOL_BITS-1:0]   vol;
        logic [PRICE_BITS-1:0] price;
        logic [ID_BITS-1:0]    ask_id;
        logic                  full;
        logic                  last;
    } t_fill;

    t_entry             bids [BOOK_DEPTH];
    t_entry             asks [BOOK_DEPTH];
    int                 bid_cnt;
    int                 ask_cnt;
    logic [ID_BITS-1:0] next_id;
    t_fill              expected_fills [$];

    assign o_pending = expected_fills.size();

    task automatic push_fill(input t_fill f);
        expected_fills.push_back(f);
    endtask

    task automatic match_order(input logic buy, input logic [PRICE_BITS-1:0] px,
                               input logic [VOL_BITS-1:0] qty);
        logic [ID_BITS-1:0]  oid;
        logic [VOL_BITS-1:0] rem;
        logic [VOL_BITS-1:0] tv;
        logic                done;
        logic                full;
        int                  n;
        int                  pos;
        t_fill               f;
        oid  = next_id;
        rem  = qty;
        done = 1'b0;
        full = 1'b0;
        n    = 0;
        next_id = next_id + ID_BITS'(1);
        if (buy) begin
            while (!done && ask_cnt > 0 && px >= asks[0].price) begin
                tv = (rem < asks[0].vol) ? rem : asks[0].vol;
                f = '{oid, 1'b1, tv, asks[0].price, asks[0].id, 1'b0, 1'b0};
                push_fill(f);
                n++;
                rem = rem - tv;
                asks[0].vol = asks[0].vol - tv;
                if (asks[0].vol == 0) begin
                    for (int k = 0; k < ask_cnt - 1; k++) asks[k] = asks[k+1];
                    ask_cnt--;
                end
                if (rem == 0) done = 1'b1;
            end
            if (!done) begin
                if (bid_cnt >= BOOK_DEPTH) begin
                    full = 1'b1;
                end else begin
                    pos = 0;
                    while (pos < bid_cnt && bids[pos].price >= px) pos++;
                    for (int k = bid_cnt; k > pos; k--) bids[k] = bids[k-1];
                    bids[pos] = '{px, rem, oid};
                    bid_cnt++;
                end
            end
        end else begin
            while (!done && bid_cnt > 0 && bids[0].price >= px) begin
                tv = (rem < bids[0].vol) ? rem : bids[0].vol;
                f = '{oid, 1'b1, tv, px, oid, 1'b0, 1'b0};
                push_fill(f);
                n++;
                rem = rem - tv;
                bids[0].vol = bids[0].vol - tv;
                if (bids[0].vol == 0) begin
                    for (int k = 0; k < bid_cnt - 1; k++) bids[k] = bids[k+1];
                    bid_cnt--;
                end
                if (rem == 0) done = 1'b1;
            end
            if (!done) begin
                if (ask_cnt >= BOOK_DEPTH) begin
                    full = 1'b1;
                end else begin
                    pos = 0;
                    while (pos < ask_cnt && asks[pos].price <= px) pos++;
                    for (int k = ask_cnt; k > pos; k--) asks[k] = asks[k-1];
                    asks[pos] = '{px, rem, oid};
                    ask_cnt++;
                end
            end
        end
        if (n == 0) begin
            f = '{oid, 1'b0, '0, '0, '0, 1'b0, 1'b0};
            push_fill(f);
        end
        expected_fills[$].full = full;
        expected_fills[$].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_fill got;
        t_fill exp_f;
        if (!i_rst_n) begin
            bid_cnt = 0;
            ask_cnt = 0;
            next_id = ID_BITS'(1);
            expected_fills.delete();
            o_fail_count = 0;
        end else begin
            if (i_valid) begin
                got = '{i_assigned_id, i_trade_valid, i_trade_volume, i_trade_price,
                        i_ask_order_id, i_book_full, i_last};
                if (expected_fills.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected fill beat: %p", got);
                end else begin
                    exp_f = expected_fills[0];
                    expected_fills.delete(0);
                    if (got !== exp_f) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("fill mismatch: expected %p actual %p", exp_f, got);
                    end
                end
            end
            if (i_start && !i_busy)
                match_order(i_is_buy, i_price_ticks, i_order_volume);
        end
    end

endmodule

FILE: verif/limit_order_book_matcher_test.sv
// ----------------------------------------------------------------------------
// Limit order book matcher test
// Drives directed corner orders, then random book-building and sweeping
// orders with random sender gaps except in the last third of them; the fill
// checker predicts and compares.
module limit_order_book_matcher_test;
    import lobm_pkg::*;

    localparam int RANDOM_ORDERS = 370;
    localparam int CYCLE_LIMIT   = 200000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  i_is_buy;
    logic [PRICE_BITS-1:0] i_price_ticks;
    logic [VOL_BITS-1:0]   i_order_volume;
    logic                  busy;
    logic                  o_valid;
    logic [ID_BITS-1:0]    o_assigned_id;
    logic                  o_trade_valid;
    logic [VOL_BITS-1:0]   o_trade_volume;
    logic [PRICE_BITS-1:0] o_trade_price;
    logic [ID_BITS-1:0]    o_ask_order_id;
    logic                  o_book_full;
    logic                  o_last;
    int                    fail_count;
    int                    pending;
    int                    cycles = 0;
    int                    idle_pct;

    limit_order_book_matcher dut (.*);

    lobm_fill_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_is_buy(i_is_buy),
        .i_price_ticks(i_price_ticks), .i_order_volume(i_order_volume),
        .i_busy(busy), .i_valid(o_valid), .i_assigned_id(o_assigned_id),
        .i_trade_valid(o_trade_valid), .i_trade_volume(o_trade_volume),
        .i_trade_price(o_trade_price), .i_ask_order_id(o_ask_order_id),
        .i_book_full(o_book_full), .i_last(o_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("limit_order_book_matcher test failed");
            $finish;
        end
    end

    task automatic send_order(input logic buy, input logic [PRICE_BITS-1:0] px,
                              input logic [VOL_BITS-1:0] qty);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_is_buy       <= buy;
        i_price_ticks  <= px;
        i_order_volume <= qty;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic logic [VOL_BITS-1:0] rand_qty(input int hi);
        int r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 8) return $urandom;
        if (r < 9) return '1;
        return $urandom_range(1, hi);
    endfunction

    initial begin
        int  slot;
        int  r;
        logic buy;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_is_buy       <= 1'b0;
        i_price_ticks  <= '0;
        i_order_volume <= '0;
        idle_pct = 9;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, zero volume, crossing zero-volume resting orders
        send_order(1'b0, '1, '1);
        send_order(1'b1, '0, '0);
        send_order(1'b0, '0, 32'd5);
        send_order(1'b1, '1, '0);
        send_order(1'b1, '1, 32'd3);
        send_order(1'b0, 20'd100, 32'd10);
        send_order(1'b0, 20'd100, 32'd20);
        send_order(1'b0, 20'd90, 32'd7);
        send_order(1'b1, 20'd100, 32'd30);
        send_order(1'b1, 20'd50, 32'd4);
        send_order(1'b1, 20'd50, 32'd6);
        send_order(1'b0, 20'd40, 32'd12);
        send_order(1'b0, 20'd40, '0);
        send_order(1'b1, '1, '1);
        send_order(1'b0, '0, '1);
        send_order(1'b1, 20'hAAAAA, 32'h55555555);
        send_order(1'b0, 20'h55555, 32'hAAAAAAAA);

        for (int n = 0; n < RANDOM_ORDERS; n++) begin
            idle_pct = (n < RANDOM_ORDERS / 3) ? 9 : (n < 2 * RANDOM_ORDERS / 3) ? 50 : 0;
            slot = n % 60;
            r    = $urandom_range(99);
            buy  = 1'($urandom_range(1));
            if (r < 10)
                send_order(buy, PRICE_BITS'($urandom), $urandom);
            else if (slot < 40)
                send_order(buy, buy ? 20'($urandom_range(1000, 1040))
                                    : 20'($urandom_range(1050, 1090)), rand_qty(20));
            else
                send_order(buy, buy ? 20'($urandom_range(1060, 1100))
                                    : 20'($urandom_range(990, 1030)), rand_qty(400));
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("limit_order_book_matcher test passed");
        else
            $display("limit_order_book_matcher test failed");
        $finish;
    end

endmodule
